// ----- rtl/c8_pkg.sv -----
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types and codes for the chip8 interpreter core: function codes,
// status codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package c8_pkg;

   localparam int MEMORY_SIZE_DEF   = 4096;
   localparam int STACK_DEPTH_DEF   = 16;
   localparam int SCREEN_WIDTH_DEF  = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;
   localparam int ENTRY_ADDRESS_DEF = 512;
   localparam int REG_COUNT         = 16;

   // transaction function codes
   localparam logic [2:0] FN_EXEC = 3'd0;
   localparam logic [2:0] FN_TICK = 3'd1;
   localparam logic [2:0] FN_LOAD = 3'd2;
   localparam logic [2:0] FN_ROW  = 3'd3;
   localparam logic [2:0] FN_BYTE = 3'd4;

   localparam logic [1:0] STATUS_DONE        = 2'd0;
   localparam logic [1:0] STATUS_WAIT_KEY    = 2'd1;
   localparam logic [1:0] STATUS_STACK_FAULT = 2'd2;

   // opcode groups
   localparam logic [3:0] GRP_SYS   = 4'h0;
   localparam logic [3:0] GRP_JP    = 4'h1;
   localparam logic [3:0] GRP_CALL  = 4'h2;
   localparam logic [3:0] GRP_SE    = 4'h3;
   localparam logic [3:0] GRP_SNE   = 4'h4;
   localparam logic [3:0] GRP_SER   = 4'h5;
   localparam logic [3:0] GRP_LD    = 4'h6;
   localparam logic [3:0] GRP_ADD   = 4'h7;
   localparam logic [3:0] GRP_ALU   = 4'h8;
   localparam logic [3:0] GRP_SNER  = 4'h9;
   localparam logic [3:0] GRP_LDI   = 4'hA;
   localparam logic [3:0] GRP_JPV0  = 4'hB;
   localparam logic [3:0] GRP_RND   = 4'hC;
   localparam logic [3:0] GRP_DRW   = 4'hD;
   localparam logic [3:0] GRP_KEY   = 4'hE;
   localparam logic [3:0] GRP_MISC  = 4'hF;

   // alu sub-codes
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // low-byte sub-codes
   localparam logic [7:0] NN_CLS    = 8'hE0;
   localparam logic [7:0] NN_RET    = 8'hEE;
   localparam logic [7:0] NN_SKP    = 8'h9E;
   localparam logic [7:0] NN_SKNP   = 8'hA1;
   localparam logic [7:0] NN_GET_DT = 8'h07;
   localparam logic [7:0] NN_KEY    = 8'h0A;
   localparam logic [7:0] NN_SET_DT = 8'h15;
   localparam logic [7:0] NN_SET_ST = 8'h18;
   localparam logic [7:0] NN_ADD_I  = 8'h1E;
   localparam logic [7:0] NN_FONT   = 8'h29;
   localparam logic [7:0] NN_BCD    = 8'h33;
   localparam logic [7:0] NN_STORE  = 8'h55;
   localparam logic [7:0] NN_BLOAD  = 8'h65;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_TICK, ST_LOAD, ST_RD_ISSUE, ST_RD_CAP,
      ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y, ST_EXEC, ST_FLAG,
      ST_DRAW_RD, ST_DRAW_WR, ST_BCD, ST_STORE_RD, ST_STORE_WR,
      ST_BLK_RD, ST_BLK_WR, ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_TICK, OP_LOAD, OP_RD_ISSUE, OP_RD_CAP,
      OP_FETCH_HI, OP_FETCH_LO, OP_READ_X, OP_READ_Y, OP_EXEC, OP_FLAG,
      OP_DRAW_RD, OP_DRAW_WR, OP_BCD, OP_STORE_RD, OP_STORE_WR,
      OP_BLK_RD, OP_BLK_WR
   } dp_op_type;

   typedef enum logic [2:0] {
      KIND_PLAIN, KIND_ALU, KIND_DRAW, KIND_BCD, KIND_STORE, KIND_BLOAD
   } exec_kind_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0]    func;
      exec_kind_type kind;
      logic          draw_more;
      logic          loop_last;
   } dp_stat_type;

endpackage

// ----- rtl/chip8_cpu_core_top.sv -----
// ----------------------------------------------------------------------------
// chip8_cpu_core_top
// Chip8 interpreter core: one request transaction in, one response out.
// ----------------------------------------------------------------------------
// One transaction is worked at a time on a program memory and a register
// file. Timer ticks and byte loads take their own state, row and byte reads
// an issue and a capture state, a plain instruction two opcode reads, two
// register reads and one execute. A sprite draw adds a read and a write per
// row, a block store or load over V0..VX a read and a write per register,
// BCD a write per digit and an ALU op with a flag a flag write. A finished
// response waits in an output register; the next request is taken once the
// controller returns to idle. No clearing pass runs after reset.
module chip8_cpu_core_top import c8_pkg::*; #(
   parameter int MEMORY_SIZE   = MEMORY_SIZE_DEF,
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int ENTRY_ADDRESS = ENTRY_ADDRESS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_addr,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_keys,
   input  logic [7:0]  req_rand_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic [63:0] rsp_row_bits,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_sound_on,
   output logic        rsp_screen_changed
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   c8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   c8_dp #(
      .MEMORY_SIZE   (MEMORY_SIZE),
      .STACK_DEPTH   (STACK_DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .ENTRY_ADDRESS (ENTRY_ADDRESS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_addr           (req_addr),
      .req_load_data      (req_load_data),
      .req_keys           (req_keys),
      .req_rand_byte      (req_rand_byte),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_index_value    (rsp_index_value),
      .rsp_row_bits       (rsp_row_bits),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_status         (rsp_status),
      .rsp_sound_on       (rsp_sound_on),
      .rsp_screen_changed (rsp_screen_changed)
   );

   // an accepted transaction keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request not followed by busy");

   // a response only appears while a transaction is in progress
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without transaction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_WAIT_KEY ||
                     rsp_status == STATUS_STACK_FAULT))
      else $error("bad status code");

endmodule

// ----- rtl/c8_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer for the chip8 core: steps the datapath through fetch, decode,
// execute and the multi-cycle loops, and owns the result valid flag.
// ----------------------------------------------------------------------------
module c8_ctrl import c8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (stat.func) inside
               FN_EXEC:         state_in = ST_FETCH_HI;
               FN_TICK:         state_in = ST_TICK;
               FN_LOAD:         state_in = ST_LOAD;
               FN_ROW, FN_BYTE: state_in = ST_RD_ISSUE;
               default:         state_in = ST_FINISH;
            endcase
         end
         ST_TICK:     state_in = ST_FINISH;
         ST_LOAD:     state_in = ST_FINISH;
         ST_RD_ISSUE: state_in = ST_RD_CAP;
         ST_RD_CAP:   state_in = ST_FINISH;
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_READ_X;
         ST_READ_X:   state_in = ST_READ_Y;
         ST_READ_Y:   state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (stat.kind)
               KIND_ALU:   state_in = ST_FLAG;
               KIND_DRAW:  state_in = ST_DRAW_RD;
               KIND_BCD:   state_in = ST_BCD;
               KIND_STORE: state_in = ST_STORE_RD;
               KIND_BLOAD: state_in = ST_BLK_RD;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_FLAG:     state_in = ST_FINISH;
         ST_DRAW_RD:  state_in = stat.draw_more ? ST_DRAW_WR : ST_FLAG;
         ST_DRAW_WR:  state_in = ST_DRAW_RD;
         ST_BCD:      if (stat.loop_last) state_in = ST_FINISH;
         ST_STORE_RD: state_in = ST_STORE_WR;
         ST_STORE_WR: state_in = stat.loop_last ? ST_FINISH : ST_STORE_RD;
         ST_BLK_RD:   state_in = ST_BLK_WR;
         ST_BLK_WR:   state_in = stat.loop_last ? ST_FINISH : ST_BLK_RD;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:     cmd.op = req_valid ? OP_LATCH : OP_NONE;
         ST_TICK:     cmd.op = OP_TICK;
         ST_LOAD:     cmd.op = OP_LOAD;
         ST_RD_ISSUE: cmd.op = OP_RD_ISSUE;
         ST_RD_CAP:   cmd.op = OP_RD_CAP;
         ST_FETCH_HI: cmd.op = OP_FETCH_HI;
         ST_FETCH_LO: cmd.op = OP_FETCH_LO;
         ST_READ_X:   cmd.op = OP_READ_X;
         ST_READ_Y:   cmd.op = OP_READ_Y;
         ST_EXEC:     cmd.op = OP_EXEC;
         ST_FLAG:     cmd.op = OP_FLAG;
         ST_DRAW_RD:  cmd.op = OP_DRAW_RD;
         ST_DRAW_WR:  cmd.op = OP_DRAW_WR;
         ST_BCD:      cmd.op = OP_BCD;
         ST_STORE_RD: cmd.op = OP_STORE_RD;
         ST_STORE_WR: cmd.op = OP_STORE_WR;
         ST_BLK_RD:   cmd.op = OP_BLK_RD;
         ST_BLK_WR:   cmd.op = OP_BLK_WR;
         ST_FINISH:   cmd.out_load = out_free;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/c8_dp.sv -----
// ----------------------------------------------------------------------------
// c8_dp
// Datapath of the chip8 core: register file, index, pc, return stack,
// timers, program memory, frame buffer and the result register.
// ----------------------------------------------------------------------------
module c8_dp import c8_pkg::*; #(
   parameter int MEMORY_SIZE   = MEMORY_SIZE_DEF,
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int ENTRY_ADDRESS = ENTRY_ADDRESS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_addr,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_keys,
   input  logic [7:0]  req_rand_byte,
   output logic [11:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic [63:0] rsp_row_bits,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_sound_on,
   output logic        rsp_screen_changed
);

   localparam int MA_W = $clog2(MEMORY_SIZE);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SI_W = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(SCREEN_WIDTH);
   localparam int RW   = $clog2(SCREEN_HEIGHT);
   localparam int SW   = SCREEN_WIDTH;

   function automatic logic [MA_W-1:0] mem_idx(input logic [16:0] a);
      logic [24:0] r;
      r = 25'(a);
      for (int s = 7; s >= 0; s--) begin
         if (r >= (25'(MEMORY_SIZE) << s)) r = r - (25'(MEMORY_SIZE) << s);
      end
      return r[MA_W-1:0];
   endfunction

   function automatic logic [CW-1:0] col_of(input logic [7:0] v);
      logic [13:0] r;
      r = 14'(v);
      for (int s = 5; s >= 0; s--) begin
         if (r >= (14'(SCREEN_WIDTH) << s)) r = r - (14'(SCREEN_WIDTH) << s);
      end
      return r[CW-1:0];
   endfunction

   function automatic logic [RW-1:0] row_of(input logic [7:0] v);
      logic [14:0] r;
      r = 15'(v);
      for (int s = 5; s >= 0; s--) begin
         if (r >= (15'(SCREEN_HEIGHT) << s)) r = r - (15'(SCREEN_HEIGHT) << s);
      end
      return r[RW-1:0];
   endfunction

   // decimal digit of v: hundreds, tens, ones
   function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
      logic [7:0] r;
      logic [3:0] h;
      logic [3:0] t;
      h = 4'd0;
      r = v;
      if (r >= 8'd200) begin
         h = 4'd2;
         r = r - 8'd200;
      end else if (r >= 8'd100) begin
         h = 4'd1;
         r = r - 8'd100;
      end
      t = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (r >= 8'(10 * i)) t = 4'(i);
      end
      r = r - ({4'd0, t} * 8'd10);
      case (sel)
         2'd0:    return {4'd0, h};
         2'd1:    return {4'd0, t};
         default: return r;
      endcase
   endfunction

   // latched transaction
   logic [2:0]  func_ff;
   logic [11:0] addr_ff;
   logic [7:0]  ldata_ff;
   logic [15:0] keys_ff;
   logic [7:0]  rand_ff;

   // architectural state
   logic [11:0]   pc_ff;
   logic [15:0]   i_ff;
   logic [SP_W-1:0] sp_ff;
   logic [7:0]    dt_ff;
   logic [7:0]    st_ff;

   // storage
   logic [7:0]    mem [MEMORY_SIZE];
   logic [7:0]    mem_rd_ff;
   logic [7:0]    v_mem [REG_COUNT];
   logic [REG_COUNT-1:0] v_valid_ff;
   logic [7:0]    v_rd_ff;
   logic          v_rd_valid_ff;
   logic [SW-1:0] fb_mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] fb_valid_ff;
   logic [SCREEN_HEIGHT-1:0] fb_nz_ff;
   logic [SW-1:0] fb_rd_ff;
   logic          fb_rd_valid_ff;
   logic [11:0]   stk_mem [STACK_DEPTH];

   // per-instruction working registers
   logic [7:0]    op_hi_ff;
   logic [7:0]    op_lo_ff;
   logic [7:0]    vx_ff;
   logic [CW-1:0] x0_ff;
   logic [RW-1:0] y0_ff;
   logic [3:0]    k_ff;
   logic          flag_ff;
   logic [1:0]    status_ff;
   logic          chg_ff;
   logic [63:0]   row_res_ff;
   logic [7:0]    byte_res_ff;

   // result register
   logic [11:0] rsp_pc_ff;
   logic [15:0] rsp_i_ff;
   logic [63:0] rsp_row_ff;
   logic [7:0]  rsp_byte_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_sound_ff;
   logic        rsp_chg_ff;

   // decode
   logic [3:0]  grp, x, y, n;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [7:0]  vy;
   logic [11:0] pc_plus2;
   logic [11:0] stk_top;
   logic [SP_W-1:0] sp_m1;
   logic        sp_full;
   logic        key_bit;
   logic        key_any;
   logic [3:0]  key_idx;
   logic [7:0]  alu_res;
   logic        alu_flag;
   logic        alu_wr;
   exec_kind_type kind;
   logic [7:0]  row_sum;
   logic [16:0] i_plus_k;
   logic [15:0] i_wrap_k;

   // ports of the storage
   logic [MA_W-1:0] mem_raddr, mem_waddr;
   logic            mem_we;
   logic [7:0]      mem_wdata;
   logic [3:0]      v_raddr, v_waddr;
   logic            v_we;
   logic [7:0]      v_wdata;
   logic [RW-1:0]   fb_raddr, fb_waddr;

   // sprite
   logic [7:0]      spr_rev;
   logic [SW+7:0]   mask_wide;
   logic [SW-1:0]   mask, old_row, new_row;

   assign grp = op_hi_ff[7:4];
   assign x   = op_hi_ff[3:0];
   assign nn  = op_lo_ff;
   assign y   = op_lo_ff[7:4];
   assign n   = op_lo_ff[3:0];
   assign nnn = {x, nn};
   assign vy  = v_rd_valid_ff ? v_rd_ff : 8'd0;
   assign pc_plus2 = pc_ff + 12'd2;
   assign sp_m1    = sp_ff - SP_W'(1);
   assign stk_top  = stk_mem[sp_m1[SI_W-1:0]];
   assign sp_full  = (sp_ff >= SP_W'(STACK_DEPTH));
   assign key_bit  = keys_ff[vx_ff[3:0]];
   assign key_any  = |keys_ff;
   assign row_sum  = 8'(y0_ff) + 8'(k_ff);
   assign i_plus_k = 17'(i_ff) + 17'(k_ff);
   assign i_wrap_k = i_ff + 16'(k_ff);
   assign fb_waddr = row_sum[RW-1:0];

   always_comb begin
      key_idx = 4'd0;
      for (int b = 15; b >= 0; b--) begin
         if (keys_ff[b]) key_idx = 4'(b);
      end
   end

   always_comb begin
      logic [8:0] sum9;
      sum9     = {1'b0, vx_ff} + {1'b0, vy};
      alu_res  = vx_ff;
      alu_flag = 1'b0;
      alu_wr   = 1'b1;
      case (n)
         ALU_MOV: alu_res = vy;
         ALU_OR:  alu_res = vx_ff | vy;
         ALU_AND: alu_res = vx_ff & vy;
         ALU_XOR: alu_res = vx_ff ^ vy;
         ALU_ADD: begin
            alu_res  = sum9[7:0];
            alu_flag = sum9[8];
         end
         ALU_SUB: begin
            alu_res  = vx_ff - vy;
            alu_flag = (vy <= vx_ff);
         end
         ALU_SHR: begin
            alu_res  = {1'b0, vx_ff[7:1]};
            alu_flag = vx_ff[0];
         end
         ALU_SBN: begin
            alu_res  = vy - vx_ff;
            alu_flag = (vx_ff <= vy);
         end
         ALU_SHL: begin
            alu_res  = {vx_ff[6:0], 1'b0};
            alu_flag = vx_ff[7];
         end
         default: alu_wr = 1'b0;
      endcase
   end

   always_comb begin
      kind = KIND_PLAIN;
      unique case (grp)
         GRP_ALU: if (alu_wr && n != ALU_MOV) kind = KIND_ALU;
         GRP_DRW: kind = KIND_DRAW;
         GRP_MISC: begin
            if (nn == NN_BCD) kind = KIND_BCD;
            else if (nn == NN_STORE) kind = KIND_STORE;
            else if (nn == NN_BLOAD) kind = KIND_BLOAD;
         end
         default: kind = KIND_PLAIN;
      endcase
   end

   assign stat.func      = func_ff;
   assign stat.kind      = kind;
   assign stat.draw_more = (k_ff < n) && (row_sum < 8'(SCREEN_HEIGHT));
   assign stat.loop_last = (kind == KIND_BCD) ? (k_ff == 4'd2) : (k_ff == x);

   // sprite bit 7 lands on the leftmost column, columns past the edge drop
   always_comb begin
      for (int j = 0; j < 8; j++) spr_rev[j] = mem_rd_ff[7-j];
      mask_wide = (SW + 8)'(spr_rev) << x0_ff;
      mask      = mask_wide[SW-1:0];
      old_row   = fb_rd_valid_ff ? fb_rd_ff : '0;
      new_row   = old_row ^ mask;
   end

   // storage port selection
   always_comb begin
      mem_raddr = mem_idx(17'(pc_ff));
      fb_raddr  = '0;
      v_raddr   = x;
      mem_we    = 1'b0;
      mem_waddr = mem_idx(i_plus_k);
      mem_wdata = v_rd_valid_ff ? v_rd_ff : 8'd0;
      v_we      = 1'b0;
      v_waddr   = x;
      v_wdata   = alu_res;
      unique case (cmd.op)
         OP_FETCH_LO: mem_raddr = mem_idx(17'(pc_ff) + 17'd1);
         OP_RD_ISSUE: begin
            mem_raddr = mem_idx(17'(addr_ff));
            fb_raddr  = addr_ff[RW-1:0];
         end
         OP_DRAW_RD: begin
            mem_raddr = mem_idx({1'b0, i_wrap_k});
            fb_raddr  = row_sum[RW-1:0];
         end
         OP_BLK_RD:   mem_raddr = mem_idx(i_plus_k);
         OP_READ_Y:   v_raddr = (grp == GRP_JPV0) ? 4'd0 : y;
         OP_STORE_RD: v_raddr = k_ff;
         OP_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = mem_idx(17'(addr_ff));
            mem_wdata = ldata_ff;
         end
         OP_BCD: begin
            mem_we    = 1'b1;
            mem_wdata = bcd_digit(vx_ff, k_ff[1:0]);
         end
         OP_STORE_WR: mem_we = 1'b1;
         OP_BLK_WR: begin
            v_we    = 1'b1;
            v_waddr = k_ff;
            v_wdata = mem_rd_ff;
         end
         OP_FLAG: begin
            v_we    = 1'b1;
            v_waddr = 4'hF;
            v_wdata = {7'd0, flag_ff};
         end
         OP_EXEC: begin
            unique case (grp)
               GRP_LD: begin
                  v_we    = 1'b1;
                  v_wdata = nn;
               end
               GRP_ADD: begin
                  v_we    = 1'b1;
                  v_wdata = vx_ff + nn;
               end
               GRP_ALU: v_we = alu_wr;
               GRP_RND: begin
                  v_we    = 1'b1;
                  v_wdata = rand_ff & nn;
               end
               GRP_MISC: begin
                  if (nn == NN_GET_DT) begin
                     v_we    = 1'b1;
                     v_wdata = dt_ff;
                  end else if (nn == NN_KEY && key_any) begin
                     v_we    = 1'b1;
                     v_wdata = {4'd0, key_idx};
                  end
               end
               default: v_we = 1'b0;
            endcase
         end
         default: mem_we = 1'b0;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) v_mem[v_waddr] <= v_wdata;
      v_rd_ff <= v_mem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DRAW_WR) fb_mem[fb_waddr] <= new_row;
      fb_rd_ff <= fb_mem[fb_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EXEC && grp == GRP_CALL && !sp_full) begin
         stk_mem[sp_ff[SI_W-1:0]] <= pc_ff;
      end
   end

   // architectural control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= 12'(ENTRY_ADDRESS);
         i_ff           <= 16'd0;
         sp_ff          <= '0;
         dt_ff          <= 8'd0;
         st_ff          <= 8'd0;
         v_valid_ff     <= '0;
         v_rd_valid_ff  <= 1'b0;
         fb_valid_ff    <= '0;
         fb_nz_ff       <= '0;
         fb_rd_valid_ff <= 1'b0;
      end else begin
         v_rd_valid_ff  <= v_valid_ff[v_raddr];
         fb_rd_valid_ff <= fb_valid_ff[fb_raddr];
         if (v_we) v_valid_ff[v_waddr] <= 1'b1;
         case (cmd.op)
            OP_TICK: begin
               if (dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
               if (st_ff != 8'd0) st_ff <= st_ff - 8'd1;
            end
            OP_READ_X: pc_ff <= pc_plus2;
            OP_DRAW_WR: begin
               fb_valid_ff[fb_waddr] <= 1'b1;
               fb_nz_ff[fb_waddr]    <= |new_row;
            end
            OP_EXEC: begin
               unique case (grp)
                  GRP_SYS: begin
                     if (nn == NN_CLS) begin
                        fb_valid_ff <= '0;
                        fb_nz_ff    <= '0;
                     end else if (nn == NN_RET && sp_ff != '0) begin
                        sp_ff <= sp_m1;
                        pc_ff <= stk_top;
                     end
                  end
                  GRP_JP: pc_ff <= nnn;
                  GRP_CALL: begin
                     if (!sp_full) begin
                        sp_ff <= sp_ff + SP_W'(1);
                        pc_ff <= nnn;
                     end
                  end
                  GRP_SE:   if (vx_ff == nn) pc_ff <= pc_plus2;
                  GRP_SNE:  if (vx_ff != nn) pc_ff <= pc_plus2;
                  GRP_SER:  if (n == 4'd0 && vx_ff == vy) pc_ff <= pc_plus2;
                  GRP_SNER: if (vx_ff != vy) pc_ff <= pc_plus2;
                  GRP_LDI:  i_ff <= {4'd0, nnn};
                  GRP_JPV0: pc_ff <= nnn + {4'd0, vy};
                  GRP_KEY: begin
                     if ((nn == NN_SKP && key_bit) || (nn == NN_SKNP && !key_bit)) begin
                        pc_ff <= pc_plus2;
                     end
                  end
                  GRP_MISC: begin
                     case (nn)
                        NN_KEY:    if (!key_any) pc_ff <= pc_ff - 12'd2;
                        NN_SET_DT: dt_ff <= vx_ff;
                        NN_SET_ST: st_ff <= vx_ff;
                        NN_ADD_I:  i_ff <= i_ff + {8'd0, vx_ff};
                        NN_FONT:   i_ff <= {6'd0, vx_ff, 2'd0} + {8'd0, vx_ff};
                        default:   i_ff <= i_ff;
                     endcase
                  end
                  default: pc_ff <= pc_ff;
               endcase
            end
            default: pc_ff <= pc_ff;
         endcase
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            func_ff     <= req_func;
            addr_ff     <= req_addr;
            ldata_ff    <= req_load_data;
            keys_ff     <= req_keys;
            rand_ff     <= req_rand_byte;
            status_ff   <= STATUS_DONE;
            chg_ff      <= 1'b0;
            row_res_ff  <= 64'd0;
            byte_res_ff <= 8'd0;
         end
         OP_RD_CAP: begin
            if (func_ff == FN_ROW && addr_ff < 12'(SCREEN_HEIGHT) && fb_rd_valid_ff) begin
               row_res_ff <= 64'(fb_rd_ff);
            end
            if (func_ff == FN_BYTE) byte_res_ff <= mem_rd_ff;
         end
         OP_FETCH_LO: op_hi_ff <= mem_rd_ff;
         OP_READ_X:   op_lo_ff <= mem_rd_ff;
         OP_READ_Y:   vx_ff    <= v_rd_valid_ff ? v_rd_ff : 8'd0;
         OP_EXEC: begin
            k_ff    <= 4'd0;
            // a draw collects its collision flag from zero
            flag_ff <= (grp == GRP_DRW) ? 1'b0 : alu_flag;
            x0_ff   <= col_of(vx_ff);
            y0_ff   <= row_of(vy);
            if (grp == GRP_SYS && nn == NN_CLS) chg_ff <= |fb_nz_ff;
            if (grp == GRP_SYS && nn == NN_RET && sp_ff == '0) status_ff <= STATUS_STACK_FAULT;
            if (grp == GRP_CALL && sp_full) status_ff <= STATUS_STACK_FAULT;
            if (grp == GRP_MISC && nn == NN_KEY && !key_any) status_ff <= STATUS_WAIT_KEY;
         end
         OP_DRAW_WR: begin
            flag_ff <= flag_ff | (|(old_row & mask));
            chg_ff  <= chg_ff | (|mask);
            k_ff    <= k_ff + 4'd1;
         end
         OP_BCD, OP_STORE_WR, OP_BLK_WR: k_ff <= k_ff + 4'd1;
         default: k_ff <= k_ff;
      endcase
      if (cmd.out_load) begin
         rsp_pc_ff     <= pc_ff;
         rsp_i_ff      <= i_ff;
         rsp_row_ff    <= row_res_ff;
         rsp_byte_ff   <= byte_res_ff;
         rsp_status_ff <= status_ff;
         rsp_sound_ff  <= (st_ff != 8'd0);
         rsp_chg_ff    <= chg_ff;
      end
   end

   assign rsp_next_pc        = rsp_pc_ff;
   assign rsp_index_value    = rsp_i_ff;
   assign rsp_row_bits       = rsp_row_ff;
   assign rsp_byte_out       = rsp_byte_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sound_on       = rsp_sound_ff;
   assign rsp_screen_changed = rsp_chg_ff;

endmodule
